[sv/ptom_pkg.sv]
`timescale 1ns / 1ps
// Shared constants, status codes and the queued order type of the matcher.
package ptom_pkg;

  localparam int BOOK_DEPTH  = 32;
  localparam int SLOTS       = 2 * BOOK_DEPTH;
  localparam int SEEN_DEPTH  = 1024;
  localparam int QUEUE_DEPTH = 2;

  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int SCAN_W  = $clog2(SLOTS + 1);
  localparam int SEEN_AW = $clog2(SEEN_DEPTH);
  localparam int SEEN_CW = $clog2(SEEN_DEPTH + 1);

  localparam logic [1:0] CMD_LIMIT  = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd2;

  localparam logic SIDE_BUY = 1'b0;

  localparam logic [2:0] ST_TRADE     = 3'd0;
  localparam logic [2:0] ST_RESTED    = 3'd1;
  localparam logic [2:0] ST_DONE      = 3'd2;
  localparam logic [2:0] ST_DUPLICATE = 3'd3;
  localparam logic [2:0] ST_REJECT    = 3'd4;
  localparam logic [2:0] ST_CANCELLED = 3'd5;
  localparam logic [2:0] ST_MISS      = 3'd6;
  localparam logic [2:0] ST_FULL      = 3'd7;

  typedef struct packed {
    logic        dup;
    logic [1:0]  cmd;
    logic        side;
    logic [15:0] instrument;
    logic [15:0] client;
    logic [63:0] seq;
    logic [31:0] price;
    logic [31:0] qty;
    logic [63:0] target;
  } order_t;

endpackage

[sv/ptom_front.sv]
`timescale 1ns / 1ps
// Front end: takes orders, checks the seen store for repeated ids and queues them.
module ptom_front import ptom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        order_valid,
  output logic        order_ready,
  input  logic [1:0]  cmd,
  input  logic        side,
  input  logic [15:0] instrument,
  input  logic [15:0] client,
  input  logic [63:0] order_sequence,
  input  logic [31:0] limit_price,
  input  logic [31:0] order_quantity,
  input  logic [63:0] cancel_target,
  output logic        q_valid,
  input  logic        q_ready,
  output order_t      q_data
);

  typedef enum logic [1:0] {F_IDLE, F_SCAN, F_PUSH} fstate_t;

  fstate_t              state;
  order_t               cur;
  logic [SEEN_CW-1:0]   idx;
  logic [SEEN_CW-1:0]   fill;
  logic [SEEN_AW-1:0]   ptr;
  logic                 cmp_vld;
  logic [63:0]          rd_data;
  logic [63:0]          mem [SEEN_DEPTH];
  logic                 hit;
  logic                 rd_en;
  logic                 wr_en;

  assign hit         = rd_data == cur.seq;
  assign rd_en       = (state == F_SCAN) && !(cmp_vld && hit) && (idx < fill);
  assign wr_en       = (state == F_PUSH) && q_ready && !cur.dup;
  assign order_ready = state == F_IDLE;
  assign q_valid     = state == F_PUSH;
  assign q_data      = cur;

  always_ff @(posedge clk) begin
    if (wr_en) mem[ptr] <= cur.seq;
    if (rd_en) rd_data <= mem[idx[SEEN_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= F_IDLE;
      fill    <= '0;
      ptr     <= '0;
      cmp_vld <= 1'b0;
      idx     <= '0;
    end else begin
      unique case (state)
        F_IDLE: begin
          if (order_valid) begin
            cur.dup        <= 1'b0;
            cur.cmd        <= cmd;
            cur.side       <= side;
            cur.instrument <= instrument;
            cur.client     <= client;
            cur.seq        <= order_sequence;
            cur.price      <= limit_price;
            cur.qty        <= order_quantity;
            cur.target     <= cancel_target;
            idx            <= '0;
            cmp_vld        <= 1'b0;
            state          <= F_SCAN;
          end
        end
        F_SCAN: begin
          cmp_vld <= rd_en;
          if (rd_en) idx <= idx + 1'b1;
          if (cmp_vld && hit) begin
            cur.dup <= 1'b1;
            state   <= F_PUSH;
          end else if (!rd_en && !cmp_vld) begin
            state <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            if (!cur.dup) begin
              ptr <= (ptr == SEEN_AW'(SEEN_DEPTH - 1)) ? '0 : ptr + 1'b1;
              if (fill != SEEN_CW'(SEEN_DEPTH)) fill <= fill + 1'b1;
            end
            state <= F_IDLE;
          end
        end
        default: state <= F_IDLE;
      endcase
    end
  end

endmodule

[sv/ptom_fifo.sv]
`timescale 1ns / 1ps
// Short queue of classified orders between the front and back ends.
module ptom_fifo import ptom_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push_valid,
  output logic   push_ready,
  input  order_t push_data,
  output logic   pop_valid,
  input  logic   pop_ready,
  output order_t pop_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  order_t          ent [QUEUE_DEPTH];
  logic [PW-1:0]   wp;
  logic [PW-1:0]   rp;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  assign push_ready = count != CW'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = ent[rp];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) ent[wp] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) wp <= (wp == PW'(QUEUE_DEPTH - 1)) ? '0 : wp + 1'b1;
      if (do_pop)  rp <= (rp == PW'(QUEUE_DEPTH - 1)) ? '0 : rp + 1'b1;
      if (do_push && !do_pop)      count <= count + 1'b1;
      else if (do_pop && !do_push) count <= count - 1'b1;
    end
  end

endmodule

[sv/ptom_back.sv]
`timescale 1ns / 1ps
// Back end: holds the books and carries out cancels, self-match walks, fills and rests.
module ptom_back import ptom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        q_valid,
  output logic        q_ready,
  input  order_t      q_data,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic [15:0] trade_instrument,
  output logic [63:0] resting_sequence,
  output logic [63:0] incoming_sequence,
  output logic [31:0] trade_quantity,
  output logic [31:0] trade_price,
  output logic        last
);

  typedef struct packed {
    logic [15:0] instrument;
    logic [15:0] client;
    logic [63:0] seq;
    logic [31:0] price;
    logic [31:0] qty;
  } entry_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] instrument;
    logic [63:0] rseq;
    logic [63:0] iseq;
    logic [31:0] qty;
    logic [31:0] price;
    logic        last;
  } res_t;

  typedef enum logic [3:0] {
    B_IDLE, B_DUP, B_CSCAN, B_CDEC, B_WSCAN, B_WDEC,
    B_MSCAN, B_MDEC, B_FINAL, B_FSCAN, B_FDEC
  } bstate_t;

  function automatic logic ahead(input logic book,
                                 input logic [31:0] pa, input logic [63:0] sa,
                                 input logic [SLOT_W-1:0] ia,
                                 input logic [31:0] pb, input logic [63:0] sb,
                                 input logic [SLOT_W-1:0] ib);
    logic r;
    if (pa != pb)      r = (book == SIDE_BUY) ? (pa > pb) : (pa < pb);
    else if (sa != sb) r = sa < sb;
    else               r = ia < ib;
    return r;
  endfunction

  function automatic res_t mk(input logic [2:0] st, input logic [15:0] ins,
                              input logic [63:0] rs, input logic [63:0] is,
                              input logic [31:0] q, input logic [31:0] p,
                              input logic l);
    res_t r;
    r.status = st; r.instrument = ins; r.rseq = rs; r.iseq = is;
    r.qty = q; r.price = p; r.last = l;
    return r;
  endfunction

  bstate_t             state;
  order_t              o;
  res_t                res;
  entry_t              mem [SLOTS];
  entry_t              rd_data;
  entry_t              best;
  entry_t              wr_data;
  logic [SLOTS-1:0]    vld;
  logic [31:0]         left;
  logic                prev_vld;
  logic [31:0]         prev_price;
  logic [63:0]         prev_seq;
  logic [SLOT_W-1:0]   prev_slot;
  logic                best_vld;
  logic [SLOT_W-1:0]   best_slot;
  logic [SCAN_W-1:0]   idx;
  logic                cmp_vld;
  logic [SLOT_W-1:0]   cmp_slot;
  logic                free_vld;
  logic [SLOT_W-1:0]   free_slot;

  logic                opp;
  logic [SCAN_W-1:0]   opp_lo;
  logic [SCAN_W-1:0]   side_lo;
  logic [SCAN_W-1:0]   scan_hi;
  logic [SCAN_W-1:0]   side_hi;
  logic                scanning;
  logic                rd_en;
  logic                cancel_hit;
  logic                cand_ok;
  logic                take_best;
  logic                upd;
  logic                is_limit;
  logic                blocked;
  logic                can_load;
  logic                res_load;
  logic [31:0]         fill_qty;
  logic [31:0]         walk_left;
  logic                wr_en;
  logic [SLOT_W-1:0]   wr_addr;

  assign opp      = ~o.side;
  assign opp_lo   = opp ? SCAN_W'(BOOK_DEPTH) : '0;
  assign side_lo  = o.side ? SCAN_W'(BOOK_DEPTH) : '0;
  assign side_hi  = side_lo + SCAN_W'(BOOK_DEPTH);
  assign scan_hi  = (state == B_CSCAN) ? SCAN_W'(SLOTS) : opp_lo + SCAN_W'(BOOK_DEPTH);
  assign scanning = (state == B_CSCAN) || (state == B_WSCAN) || (state == B_MSCAN);
  assign rd_en    = scanning && (idx < scan_hi);

  assign cancel_hit = vld[cmp_slot] && (rd_data.seq == o.target) && !best_vld;
  assign cand_ok    = vld[cmp_slot] && (rd_data.instrument == o.instrument) &&
                      (!prev_vld || ahead(opp, prev_price, prev_seq, prev_slot,
                                          rd_data.price, rd_data.seq, cmp_slot));
  assign take_best  = cand_ok && (!best_vld || ahead(opp, rd_data.price, rd_data.seq,
                                                     cmp_slot, best.price, best.seq,
                                                     best_slot));
  assign upd        = (state == B_CSCAN) ? cancel_hit : take_best;

  assign is_limit  = o.cmd == CMD_LIMIT;
  assign blocked   = is_limit && ((o.side == SIDE_BUY) ? (o.price < best.price)
                                                       : (o.price > best.price));
  assign can_load  = !result_valid || result_ready;
  assign fill_qty  = (left < best.qty) ? left : best.qty;
  assign walk_left = (left > best.qty) ? left - best.qty : '0;
  assign q_ready   = state == B_IDLE;

  // A new result enters the output register in exactly these cases.
  assign res_load = can_load &&
                    ((state == B_DUP) || (state == B_CDEC) || (state == B_FDEC) ||
                     (state == B_WDEC && best_vld && !blocked && left != '0 &&
                      best.client == o.client) ||
                     (state == B_MDEC && best_vld && !blocked) ||
                     (state == B_FINAL && !(left != '0 && is_limit)));

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = best_slot;
    wr_data = best;
    if (state == B_MDEC && best_vld && !blocked && can_load) begin
      wr_en       = 1'b1;
      wr_data.qty = best.qty - fill_qty;
    end else if (state == B_FDEC && free_vld && can_load) begin
      wr_en              = 1'b1;
      wr_addr            = free_slot;
      wr_data.instrument = o.instrument;
      wr_data.client     = o.client;
      wr_data.seq        = o.seq;
      wr_data.price      = o.price;
      wr_data.qty        = left;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data <= mem[idx[SLOT_W-1:0]];
  end

  assign status            = res.status;
  assign trade_instrument  = res.instrument;
  assign resting_sequence  = res.rseq;
  assign incoming_sequence = res.iseq;
  assign trade_quantity    = res.qty;
  assign trade_price       = res.price;
  assign last              = res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= B_IDLE;
      result_valid <= 1'b0;
      vld          <= '0;
      cmp_vld      <= 1'b0;
      best_vld     <= 1'b0;
      prev_vld     <= 1'b0;
      free_vld     <= 1'b0;
      idx          <= '0;
    end else begin
      result_valid <= res_load || (result_valid && !result_ready);
      unique case (state)
        B_IDLE: begin
          if (q_valid) begin
            o        <= q_data;
            left     <= q_data.qty;
            prev_vld <= 1'b0;
            best_vld <= 1'b0;
            cmp_vld  <= 1'b0;
            if (q_data.dup) begin
              state <= B_DUP;
            end else if (q_data.cmd == CMD_CANCEL) begin
              idx   <= '0;
              state <= B_CSCAN;
            end else begin
              idx   <= q_data.side ? '0 : SCAN_W'(BOOK_DEPTH);
              state <= B_WSCAN;
            end
          end
        end
        B_DUP: begin
          if (can_load) begin
            res   <= mk(ST_DUPLICATE, o.instrument, '0, o.seq, '0, '0, 1'b1);
            state <= B_IDLE;
          end
        end
        B_CSCAN, B_WSCAN, B_MSCAN: begin
          cmp_vld  <= rd_en;
          cmp_slot <= idx[SLOT_W-1:0];
          if (rd_en) idx <= idx + 1'b1;
          if (cmp_vld && upd) begin
            best      <= rd_data;
            best_slot <= cmp_slot;
            best_vld  <= 1'b1;
          end
          if (!rd_en && !cmp_vld) begin
            if (state == B_CSCAN)      state <= B_CDEC;
            else if (state == B_WSCAN) state <= B_WDEC;
            else                       state <= B_MDEC;
          end
        end
        B_CDEC: begin
          if (can_load) begin
            if (best_vld) begin
              res <= mk(ST_CANCELLED, best.instrument, o.target, o.seq,
                        best.qty, best.price, 1'b1);
              vld[best_slot] <= 1'b0;
            end else begin
              res <= mk(ST_MISS, o.instrument, o.target, o.seq, '0, '0, 1'b1);
            end
            state <= B_IDLE;
          end
        end
        B_WDEC: begin
          if (!best_vld || blocked || left == '0) begin
            left     <= o.qty;
            prev_vld <= 1'b0;
            best_vld <= 1'b0;
            idx      <= opp_lo;
            state    <= (o.qty == '0) ? B_FINAL : B_MSCAN;
          end else if (best.client == o.client) begin
            if (can_load) begin
              res   <= mk(ST_REJECT, o.instrument, '0, o.seq, o.qty, '0, 1'b1);
              state <= B_IDLE;
            end
          end else begin
            left       <= walk_left;
            prev_vld   <= 1'b1;
            prev_price <= best.price;
            prev_seq   <= best.seq;
            prev_slot  <= best_slot;
            best_vld   <= 1'b0;
            idx        <= opp_lo;
            state      <= B_WSCAN;
          end
        end
        B_MDEC: begin
          if (!best_vld || blocked) begin
            state <= B_FINAL;
          end else if (can_load) begin
            res <= mk(ST_TRADE, o.instrument, best.seq, o.seq, fill_qty, best.price, 1'b0);
            left <= left - fill_qty;
            if (best.qty == fill_qty) vld[best_slot] <= 1'b0;
            best_vld <= 1'b0;
            idx      <= opp_lo;
            state    <= (left == fill_qty) ? B_FINAL : B_MSCAN;
          end
        end
        B_FINAL: begin
          if (left != '0 && is_limit) begin
            idx      <= side_lo;
            free_vld <= 1'b0;
            state    <= B_FSCAN;
          end else if (can_load) begin
            res   <= mk(ST_DONE, o.instrument, '0, o.seq, left, '0, 1'b1);
            state <= B_IDLE;
          end
        end
        B_FSCAN: begin
          if (idx == side_hi) begin
            state <= B_FDEC;
          end else if (!vld[idx[SLOT_W-1:0]]) begin
            free_vld  <= 1'b1;
            free_slot <= idx[SLOT_W-1:0];
            state     <= B_FDEC;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        B_FDEC: begin
          if (can_load) begin
            if (free_vld) begin
              vld[free_slot] <= 1'b1;
              res <= mk(ST_RESTED, o.instrument, '0, o.seq, left, o.price, 1'b1);
            end else begin
              res <= mk(ST_FULL, o.instrument, '0, o.seq, left, o.price, 1'b1);
            end
            state <= B_IDLE;
          end
        end
        default: state <= B_IDLE;
      endcase
    end
  end

endmodule

[sv/price_time_order_matcher.sv]
`timescale 1ns / 1ps
// Top level of the price-time priority order matcher.
// The matcher takes limit, market and cancel orders one transfer at a time and answers each
// with zero or more trade results followed by exactly one final result marked by last. The
// front end first compares the order id with the ids held in the seen store, one entry a
// cycle from its single memory port, until it finds a match or has read them all. The order
// then waits in a two-entry queue while the back end works through the books. Every search
// of a book (the self-match walk, each fill and each cancel) is a sweep of one book slot a
// cycle followed by a decision state; a walk or fill sweeps one side, while a cancel
// searches both books. When a limit order leaves a remainder, the back end scans its own
// book for a free slot to rest it in. Front and back overlap, so the seen-store check of one
// order runs while the previous one is being matched. No clearing pass is needed after
// reset: the books start empty through their valid bits and the seen store through its
// fill count.
module price_time_order_matcher import ptom_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        order_valid,
  output logic        order_ready,
  input  logic [1:0]  cmd,
  input  logic        side,
  input  logic [15:0] instrument,
  input  logic [15:0] client,
  input  logic [63:0] order_sequence,
  input  logic [31:0] limit_price,
  input  logic [31:0] order_quantity,
  input  logic [63:0] cancel_target,
  output logic        result_valid,
  input  logic        result_ready,
  output logic [2:0]  status,
  output logic [15:0] trade_instrument,
  output logic [63:0] resting_sequence,
  output logic [63:0] incoming_sequence,
  output logic [31:0] trade_quantity,
  output logic [31:0] trade_price,
  output logic        last
);

  // Classified orders from the front end, with the duplicate flag attached.
  order_t front_data;
  order_t back_data;
  logic   front_valid;
  logic   front_ready;
  logic   back_valid;
  logic   back_ready;

  ptom_front u_front (
    .clk            (clk),
    .rst            (rst),
    .order_valid    (order_valid),
    .order_ready    (order_ready),
    .cmd            (cmd),
    .side           (side),
    .instrument     (instrument),
    .client         (client),
    .order_sequence (order_sequence),
    .limit_price    (limit_price),
    .order_quantity (order_quantity),
    .cancel_target  (cancel_target),
    .q_valid        (front_valid),
    .q_ready        (front_ready),
    .q_data         (front_data)
  );

  // The queue lets the front end check the next id while the back end is still busy.
  ptom_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_data  (front_data),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_data   (back_data)
  );

  // The back end owns both books and the registered result stage.
  ptom_back u_back (
    .clk               (clk),
    .rst               (rst),
    .q_valid           (back_valid),
    .q_ready           (back_ready),
    .q_data            (back_data),
    .result_valid      (result_valid),
    .result_ready      (result_ready),
    .status            (status),
    .trade_instrument  (trade_instrument),
    .resting_sequence  (resting_sequence),
    .incoming_sequence (incoming_sequence),
    .trade_quantity    (trade_quantity),
    .trade_price       (trade_price),
    .last              (last)
  );

endmodule

[sv/ptom_checker.sv]
`timescale 1ns / 1ps
// Port-level checker for the matcher, bound to the top level.
module ptom_checker import ptom_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        result_valid,
  input logic        result_ready,
  input logic [2:0]  status,
  input logic [63:0] resting_sequence,
  input logic [31:0] trade_quantity,
  input logic        last
);

  // Trades are never final; every other status closes the order.
  a_last_status: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> ((status == ST_TRADE) == !last))
    else $error("last does not match status");

  // A trade always moves some quantity.
  a_trade_qty: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_TRADE |-> trade_quantity != '0)
    else $error("trade with zero quantity");

  // A duplicate carries no resting id and no quantity.
  a_dup_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_DUPLICATE |-> resting_sequence == '0 && trade_quantity == '0)
    else $error("duplicate result carries data");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(status) && $stable(last))
    else $error("result changed while stalled");

  // No result straight after reset.
  a_reset: assert property (@(posedge clk) $fell(rst) |-> !result_valid)
    else $error("result valid after reset");

endmodule

bind price_time_order_matcher ptom_checker u_checker (
  .clk              (clk),
  .rst              (rst),
  .result_valid     (result_valid),
  .result_ready     (result_ready),
  .status           (status),
  .resting_sequence (resting_sequence),
  .trade_quantity   (trade_quantity),
  .last             (last)
);

[tb/price_time_order_matcher_tb.sv]
`timescale 1ns / 1ps
// Self-checking testbench of the price-time priority order matcher.
module price_time_order_matcher_tb;
  import ptom_pkg::*;

  // Command codes and a side value that the package does not name.
  localparam logic [1:0] CMD_MARKET = 2'd1;
  localparam logic [1:0] CMD_SPARE  = 2'd3;
  localparam logic       SIDE_SELL  = 1'b1;
  localparam int         CYCLE_LIMIT = 4000000;
  localparam int         TAIL_CYCLES = 3000;

  typedef struct {
    logic [1:0]  cmd;
    logic        side;
    logic [15:0] instrument;
    logic [15:0] client;
    logic [63:0] seq;
    logic [31:0] price;
    logic [31:0] qty;
    logic [63:0] target;
    bit          calm;
    bit          drain_first;
  } order_item_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] instrument;
    logic [63:0] resting_seq;
    logic [63:0] incoming_seq;
    logic [31:0] qty;
    logic [31:0] price;
    logic        last;
  } fill_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        order_valid = 1'b0;
  logic        order_ready;
  logic [1:0]  cmd = '0;
  logic        side = 1'b0;
  logic [15:0] instrument = '0;
  logic [15:0] client = '0;
  logic [63:0] order_sequence = '0;
  logic [31:0] limit_price = '0;
  logic [31:0] order_quantity = '0;
  logic [63:0] cancel_target = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] trade_instrument;
  logic [63:0] resting_sequence;
  logic [63:0] incoming_sequence;
  logic [31:0] trade_quantity;
  logic [31:0] trade_price;
  logic        last;

  price_time_order_matcher uut (
    .clk(clk), .rst(rst),
    .order_valid(order_valid), .order_ready(order_ready),
    .cmd(cmd), .side(side), .instrument(instrument), .client(client),
    .order_sequence(order_sequence), .limit_price(limit_price),
    .order_quantity(order_quantity), .cancel_target(cancel_target),
    .result_valid(result_valid), .result_ready(result_ready),
    .status(status), .trade_instrument(trade_instrument),
    .resting_sequence(resting_sequence), .incoming_sequence(incoming_sequence),
    .trade_quantity(trade_quantity), .trade_price(trade_price), .last(last)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  order_item_t  order_backlog[$];
  fill_report_t awaited_results[$];
  logic [63:0]  issued_ids[$];

  int  fail_count = 0;
  int  orders_taken = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  bit  order_taken = 1'b0;
  bit  cur_calm = 1'b0;

  // Shadow copy of the two books and of the seen-id ring.
  bit          bk_live[SLOTS];
  logic [15:0] bk_instr[SLOTS];
  logic [15:0] bk_client[SLOTS];
  logic [63:0] bk_seq[SLOTS];
  logic [31:0] bk_price[SLOTS];
  logic [31:0] bk_qty[SLOTS];
  logic [63:0] seen_id[SEEN_DEPTH];
  bit          seen_ok[SEEN_DEPTH];
  int          seen_wr = 0;

  // True when slot a has priority over slot b in the given book (0 bids, 1 asks).
  function automatic bit ranks_ahead(bit book, int a, int b);
    if (bk_price[a] != bk_price[b])
      return book == 1'b0 ? bk_price[a] > bk_price[b] : bk_price[a] < bk_price[b];
    if (bk_seq[a] != bk_seq[b])
      return bk_seq[a] < bk_seq[b];
    return a < b;
  endfunction

  // Best live entry of a book and instrument that ranks after prev.
  function automatic int best_after(bit book, logic [15:0] ins, int prev);
    int best;
    int s;
    best = -1;
    for (s = book * BOOK_DEPTH; s < (book + 1) * BOOK_DEPTH; s++) begin
      if (bk_live[s] && bk_instr[s] == ins && (prev < 0 || ranks_ahead(book, prev, s))) begin
        if (best < 0 || ranks_ahead(book, s, best))
          best = s;
      end
    end
    return best;
  endfunction

  function automatic bit price_blocks(logic sd, bit is_limit, logic [31:0] lim, int s);
    if (!is_limit)
      return 1'b0;
    return sd == SIDE_BUY ? lim < bk_price[s] : lim > bk_price[s];
  endfunction

  task automatic await_result(logic [2:0] st, logic [15:0] ins, logic [63:0] rseq,
                              logic [63:0] iseq, logic [31:0] q, logic [31:0] p, logic l);
    fill_report_t r;
    r.status = st; r.instrument = ins; r.resting_seq = rseq;
    r.incoming_seq = iseq; r.qty = q; r.price = p; r.last = l;
    awaited_results.insert(awaited_results.size(), r);
  endtask

  // Works out every result one accepted order causes and updates the shadow books.
  task automatic match_order(logic [1:0] c, logic sd, logic [15:0] ins, logic [15:0] cli,
                             logic [63:0] sq, logic [31:0] lim, logic [31:0] q,
                             logic [63:0] tgt);
    bit          is_limit;
    bit          opp;
    int          i;
    int          s;
    int          prev;
    int          free_slot;
    logic [31:0] left;
    logic [31:0] fill;
    is_limit = (c == CMD_LIMIT);
    opp = ~sd;
    for (i = 0; i < SEEN_DEPTH; i++) begin
      if (seen_ok[i] && seen_id[i] == sq) begin
        await_result(ST_DUPLICATE, ins, '0, sq, '0, '0, 1'b1);
        return;
      end
    end
    seen_id[seen_wr] = sq;
    seen_ok[seen_wr] = 1'b1;
    seen_wr = (seen_wr + 1) % SEEN_DEPTH;

    if (c == CMD_CANCEL) begin
      for (s = 0; s < SLOTS; s++) begin
        if (bk_live[s] && bk_seq[s] == tgt) begin
          await_result(ST_CANCELLED, bk_instr[s], tgt, sq, bk_qty[s], bk_price[s], 1'b1);
          bk_live[s] = 1'b0;
          return;
        end
      end
      await_result(ST_MISS, ins, tgt, sq, '0, '0, 1'b1);
      return;
    end

    // The self-match walk looks at every entry that the order would reach.
    left = q;
    prev = -1;
    forever begin
      s = best_after(opp, ins, prev);
      if (s < 0 || price_blocks(sd, is_limit, lim, s) || left == 0)
        break;
      if (bk_client[s] == cli) begin
        await_result(ST_REJECT, ins, '0, sq, q, '0, 1'b1);
        return;
      end
      left = left > bk_qty[s] ? left - bk_qty[s] : '0;
      prev = s;
    end

    left = q;
    while (left > 0) begin
      s = best_after(opp, ins, -1);
      if (s < 0 || price_blocks(sd, is_limit, lim, s))
        break;
      fill = left < bk_qty[s] ? left : bk_qty[s];
      await_result(ST_TRADE, ins, bk_seq[s], sq, fill, bk_price[s], 1'b0);
      left -= fill;
      bk_qty[s] -= fill;
      if (bk_qty[s] == 0)
        bk_live[s] = 1'b0;
    end

    if (left > 0 && is_limit) begin
      free_slot = -1;
      for (s = sd * BOOK_DEPTH; s < (sd + 1) * BOOK_DEPTH; s++) begin
        if (!bk_live[s] && free_slot < 0)
          free_slot = s;
      end
      if (free_slot < 0) begin
        await_result(ST_FULL, ins, '0, sq, left, lim, 1'b1);
        return;
      end
      bk_live[free_slot] = 1'b1;
      bk_instr[free_slot] = ins;
      bk_client[free_slot] = cli;
      bk_seq[free_slot] = sq;
      bk_price[free_slot] = lim;
      bk_qty[free_slot] = left;
      await_result(ST_RESTED, ins, '0, sq, left, lim, 1'b1);
      return;
    end
    await_result(ST_DONE, ins, '0, sq, left, '0, 1'b1);
  endtask

  task automatic queue_order(logic [1:0] c, logic sd, logic [15:0] ins, logic [15:0] cli,
                             logic [63:0] sq, logic [31:0] lim, logic [31:0] q,
                             logic [63:0] tgt, bit calm, bit drain_first);
    order_item_t it;
    it.cmd = c; it.side = sd; it.instrument = ins; it.client = cli; it.seq = sq;
    it.price = lim; it.qty = q; it.target = tgt; it.calm = calm;
    it.drain_first = drain_first;
    order_backlog.insert(order_backlog.size(), it);
    issued_ids.insert(issued_ids.size(), sq);
  endtask

  function automatic logic [63:0] fresh_id();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] known_id();
    return issued_ids[$urandom_range(issued_ids.size() - 1)];
  endfunction

  // One random order, mostly well formed around a handful of instruments and clients.
  task automatic queue_random_order(bit calm);
    int          roll;
    logic [1:0]  c;
    logic        sd;
    logic [15:0] ins;
    logic [15:0] cli;
    logic [63:0] sq;
    logic [31:0] lim;
    logic [31:0] q;
    logic [63:0] tgt;
    roll = $urandom_range(99);
    sd = 1'($urandom_range(1));
    ins = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(2));
    cli = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(4, 1));
    lim = ($urandom_range(29) == 0) ? $urandom
                                    : 32'(sd == SIDE_BUY ? $urandom_range(104, 94)
                                                         : $urandom_range(106, 96));
    q = ($urandom_range(29) == 0) ? $urandom : 32'($urandom_range(20, 1));
    sq = fresh_id();
    tgt = fresh_id();
    if (roll < 55) c = CMD_LIMIT;
    else if (roll < 70) c = CMD_MARKET;
    else if (roll < 73) c = CMD_SPARE;
    else c = CMD_CANCEL;
    if (c == CMD_CANCEL && $urandom_range(4) != 0)
      tgt = known_id();
    if ($urandom_range(99) < 6)
      sq = known_id();
    queue_order(c, sd, ins, cli, sq, lim, q, tgt, calm, 1'b0);
  endtask

  // Driver: offers a new order at the falling edge once the previous transfer has happened.
  always @(negedge clk) begin
    if (rst) begin
      order_valid <= 1'b0;
      result_ready <= 1'b0;
    end else begin
      if (!order_valid || order_taken) begin
        if (order_backlog.size() > 0 &&
            (!order_backlog[0].drain_first || awaited_results.size() == 0) &&
            (order_backlog[0].calm || $urandom_range(99) >= 6)) begin
          cmd <= order_backlog[0].cmd;
          side <= order_backlog[0].side;
          instrument <= order_backlog[0].instrument;
          client <= order_backlog[0].client;
          order_sequence <= order_backlog[0].seq;
          limit_price <= order_backlog[0].price;
          order_quantity <= order_backlog[0].qty;
          cancel_target <= order_backlog[0].target;
          cur_calm <= order_backlog[0].calm;
          order_backlog.pop_front();
          order_valid <= 1'b1;
        end else begin
          order_valid <= 1'b0;
        end
      end
      result_ready <= cur_calm || ($urandom_range(99) >= 6);
    end
  end

  // Monitor: checks each result transfer, then predicts for each order transfer.
  always @(posedge clk) begin
    fill_report_t exp_r;
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d results still awaited", awaited_results.size());
      $display("status: fail");
      $finish;
    end
    if (rst) begin
      order_taken <= 1'b0;
    end else begin
      order_taken <= order_valid && order_ready;
      if (result_valid && result_ready) begin
        results_seen++;
        if (awaited_results.size() == 0) begin
          $error("result transfer with nothing awaited: status %0d seq %h",
                 status, incoming_sequence);
          fail_count++;
        end else begin
          exp_r = awaited_results.pop_front();
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            fail_count++;
          end
          if (trade_instrument !== exp_r.instrument) begin
            $error("trade_instrument: expected %h, got %h", exp_r.instrument,
                   trade_instrument);
            fail_count++;
          end
          if (resting_sequence !== exp_r.resting_seq) begin
            $error("resting_sequence: expected %h, got %h", exp_r.resting_seq,
                   resting_sequence);
            fail_count++;
          end
          if (incoming_sequence !== exp_r.incoming_seq) begin
            $error("incoming_sequence: expected %h, got %h", exp_r.incoming_seq,
                   incoming_sequence);
            fail_count++;
          end
          if (trade_quantity !== exp_r.qty) begin
            $error("trade_quantity: expected %0d, got %0d", exp_r.qty, trade_quantity);
            fail_count++;
          end
          if (trade_price !== exp_r.price) begin
            $error("trade_price: expected %0d, got %0d", exp_r.price, trade_price);
            fail_count++;
          end
          if (last !== exp_r.last) begin
            $error("last: expected %0d, got %0d", exp_r.last, last);
            fail_count++;
          end
        end
      end
      if (order_valid && order_ready) begin
        orders_taken++;
        match_order(cmd, side, instrument, client, order_sequence, limit_price,
                    order_quantity, cancel_target);
      end
    end
  end

  initial begin
    int          i;
    logic [63:0] id_a;
    logic [63:0] id_b;
    for (i = 0; i < SLOTS; i++) bk_live[i] = 1'b0;
    for (i = 0; i < SEEN_DEPTH; i++) seen_ok[i] = 1'b0;

    // Directed orders: extremes, each command, self-match, cancels and duplicates.
    id_a = 64'd0;
    id_b = 64'hFFFF_FFFF_FFFF_FFFF;
    queue_order(CMD_LIMIT, SIDE_BUY, 16'hFFFF, 16'hFFFF, id_a, 32'd100, 32'd10, '0, 1, 0);
    queue_order(CMD_LIMIT, SIDE_SELL, 16'hFFFF, 16'h0001, id_b, 32'd90, 32'd4, id_b, 1, 0);
    queue_order(CMD_LIMIT, SIDE_SELL, 16'hFFFF, 16'hFFFF, 64'd5, 32'd100, 32'd3, '0, 1, 0);
    queue_order(CMD_MARKET, SIDE_SELL, 16'hFFFF, 16'h0002, 64'd6, 32'hFFFF_FFFF,
                32'd0, '0, 1, 0);
    queue_order(CMD_SPARE, SIDE_SELL, 16'hFFFF, 16'h0002, 64'd7, '0, 32'd2, '0, 1, 0);
    queue_order(CMD_CANCEL, SIDE_BUY, 16'h0000, 16'h0000, 64'd8, '0, '0, id_a, 1, 0);
    queue_order(CMD_CANCEL, SIDE_SELL, 16'h0000, 16'h0000, 64'd9, '0, '0, id_b, 1, 0);
    queue_order(CMD_LIMIT, SIDE_BUY, 16'h0000, 16'h0000, 64'd5, 32'd1, 32'd1, '0, 1, 0);
    queue_order(CMD_LIMIT, SIDE_SELL, 16'h0000, 16'h0003, 64'd10, 32'hFFFF_FFFF,
                32'hFFFF_FFFF, '0, 1, 0);
    queue_order(CMD_LIMIT, SIDE_SELL, 16'h0000, 16'h0004, 64'd10, 32'd7, 32'd7, '0, 1, 0);
    queue_order(CMD_LIMIT, SIDE_BUY, 16'h0000, 16'h0005, 64'd11, 32'd0, 32'd5, '0, 1, 0);
    queue_order(CMD_LIMIT, SIDE_BUY, 16'h0000, 16'h0006, 64'd12, 32'd0, 32'd5, '0, 1, 0);
    queue_order(CMD_MARKET, SIDE_BUY, 16'h0000, 16'h0007, 64'd13, '0, 32'd3, '0, 1, 0);
    queue_order(CMD_MARKET, SIDE_SELL, 16'h0000, 16'h0008, 64'd14, '0, 32'd20, '0, 1, 0);
    queue_order(CMD_LIMIT, SIDE_BUY, 16'h0000, 16'h0009, 64'h8000_0000_0000_0000,
                32'hFFFF_FFFF, 32'hFFFF_FFFF, '0, 1, 0);
    queue_order(CMD_CANCEL, SIDE_BUY, 16'h0000, 16'h0000, 64'd15, '0, '0,
                64'h8000_0000_0000_0000, 1, 0);
    queue_order(CMD_CANCEL, SIDE_BUY, 16'h0000, 16'h0000, 64'd16, '0, '0, 64'd10, 1, 0);

    // Random orders in phases: noisy, calm, and a burst that fills one bid book.
    for (i = 0; i < 120; i++) queue_random_order(1'b0);
    for (i = 0; i < 60; i++) queue_random_order(1'b1);
    queue_order(CMD_CANCEL, SIDE_BUY, 16'd1, 16'd1, fresh_id(), '0, '0, known_id(), 0, 1);
    for (i = 0; i < 36; i++)
      queue_order(CMD_LIMIT, SIDE_BUY, 16'd9, 16'($urandom_range(3, 1)), fresh_id(),
                  32'($urandom_range(12, 8)), 32'($urandom_range(6, 1)), '0, 0, 0);
    queue_order(CMD_MARKET, SIDE_SELL, 16'd9, 16'd77, fresh_id(), '0, 32'd1000, '0, 0, 0);
    for (i = 0; i < 140; i++) queue_random_order(1'b0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    wait (order_backlog.size() == 0 && !order_valid && awaited_results.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("covered %0d orders and %0d results, including a full bid book", orders_taken,
             results_seen);
    $display("failures: %0d, results left waiting: %0d", fail_count,
             awaited_results.size());
    if (fail_count == 0 && awaited_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
